// ----- hdl/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the cocktail shaker sorter.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int VALUE_W     = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               keep;
   } entry_type;

endpackage

// ----- hdl/css_front.sv -----
// ----------------------------------------------------------------------------
// css_front
// Accepts input beats and marks each one as kept or dropped by list position.
// ----------------------------------------------------------------------------
module css_front #(
   parameter int MAX_LEN = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [css_pkg::VALUE_W-1:0] req_tdata,
   input  logic                       req_tlast,
   output logic                       push_valid,
   input  logic                       push_ready,
   output css_pkg::entry_type         push_data
);

   localparam int CW = $clog2(MAX_LEN + 1);

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          keep;
   logic          accept;

   assign keep       = cnt_ff < CW'(MAX_LEN);
   assign accept     = req_tvalid && push_ready;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.value = req_tdata;
      push_data.last  = req_tlast;
      push_data.keep  = keep;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_tlast) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hdl/css_queue.sv -----
// ----------------------------------------------------------------------------
// css_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module css_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  css_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output css_pkg::entry_type pop_data
);

   css_pkg::entry_type              slot_ff [css_pkg::QUEUE_DEPTH];
   logic [css_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [css_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [css_pkg::QUEUE_AW:0]      cnt_ff;
   logic [css_pkg::QUEUE_AW:0]      cnt_in;
   logic                            do_push;
   logic                            do_pop;

   assign push_ready = cnt_ff != (css_pkg::QUEUE_AW + 1)'(css_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (css_pkg::QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (css_pkg::QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + css_pkg::QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + css_pkg::QUEUE_AW'(1);
         end
      end
   end

endmodule

// ----- hdl/css_back.sv -----
// ----------------------------------------------------------------------------
// css_back
// Stores the list, sorts it in place with shaker passes, emits the result.
// ----------------------------------------------------------------------------
module css_back #(
   parameter int MAX_LEN = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  css_pkg::entry_type          pop_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [css_pkg::VALUE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int VW = css_pkg::VALUE_W;

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_PRIME0 = 3'd1;
   localparam logic [2:0] ST_PRIME1 = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_END    = 3'd4;
   localparam logic [2:0] ST_RD     = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [VW-1:0] mem [MAX_LEN];

   logic [2:0]    state_ff,   state_in;
   logic [CW-1:0] count_ff,   count_in;
   logic          ovf_ff,     ovf_in;
   logic [AW-1:0] lo_ff,      lo_in;
   logic [AW-1:0] hi_ff,      hi_in;
   logic          dir_ff,     dir_in;
   logic [AW-1:0] idx_ff,     idx_in;
   logic [VW-1:0] carry_ff,   carry_in;
   logic [VW-1:0] rd_data_ff;
   logic          out_vld_ff, out_vld_in;
   logic [VW-1:0] out_val_ff, out_val_in;
   logic          out_lst_ff, out_lst_in;
   logic          out_drp_ff, out_drp_in;

   logic          we;
   logic [AW-1:0] waddr;
   logic [VW-1:0] wdata;
   logic [AW-1:0] rd_addr;
   logic [AW:0]   ahead;
   logic [CW-1:0] n_list;
   logic          gt;
   logic [VW-1:0] mn;
   logic [VW-1:0] mx;
   logic [AW-1:0] lo_nx;
   logic [AW-1:0] hi_nx;
   logic          out_free;

   assign gt       = $signed(carry_ff) > $signed(rd_data_ff);
   assign mn       = gt ? rd_data_ff : carry_ff;
   assign mx       = gt ? carry_ff : rd_data_ff;
   assign ahead    = dir_ff ? ({1'b0, idx_ff} - (AW + 1)'(2)) : ({1'b0, idx_ff} + (AW + 1)'(2));
   assign n_list   = pop_data.keep ? (count_ff + CW'(1)) : count_ff;
   assign lo_nx    = dir_ff ? (lo_ff + AW'(1)) : lo_ff;
   assign hi_nx    = dir_ff ? hi_ff : (hi_ff - AW'(1));
   assign out_free = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tlast  = out_lst_ff;
   assign rsp_tuser  = out_drp_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      dir_in     = dir_ff;
      idx_in     = idx_ff;
      carry_in   = carry_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      out_val_in = out_val_ff;
      out_lst_in = out_lst_ff;
      out_drp_in = out_drp_ff;
      pop_ready  = 1'b0;
      we         = 1'b0;
      waddr      = idx_ff;
      wdata      = carry_ff;
      rd_addr    = idx_ff;
      case (state_ff)
         ST_LOAD: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               if (pop_data.keep) begin
                  we       = 1'b1;
                  waddr    = AW'(count_ff);
                  wdata    = pop_data.value;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (pop_data.last) begin
                  lo_in  = '0;
                  hi_in  = AW'(n_list - CW'(1));
                  dir_in = 1'b0;
                  idx_in = '0;
                  state_in = (n_list > CW'(1)) ? ST_PRIME0 : ST_RD;
               end
            end
         end
         ST_PRIME0: begin
            idx_in   = dir_ff ? hi_ff : lo_ff;
            rd_addr  = dir_ff ? hi_ff : lo_ff;
            state_in = ST_PRIME1;
         end
         ST_PRIME1: begin
            rd_addr  = dir_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            carry_in = rd_data_ff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            we       = 1'b1;
            waddr    = idx_ff;
            wdata    = dir_ff ? mx : mn;
            carry_in = dir_ff ? mn : mx;
            rd_addr  = ahead[AW-1:0];
            idx_in   = dir_ff ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            if (dir_ff ? (idx_ff == lo_ff + AW'(1)) : (idx_ff == hi_ff - AW'(1))) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            we     = 1'b1;
            waddr  = dir_ff ? lo_ff : hi_ff;
            wdata  = carry_ff;
            lo_in  = lo_nx;
            hi_in  = hi_nx;
            dir_in = !dir_ff;
            if (lo_nx < hi_nx) begin
               state_in = ST_PRIME0;
            end else begin
               idx_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_val_in = rd_data_ff;
               out_lst_in = CW'(idx_ff) == count_ff - CW'(1);
               out_drp_in = ovf_ff;
               if (CW'(idx_ff) == count_ff - CW'(1)) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      carry_ff   <= carry_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      dir_ff     <= dir_in;
      idx_ff     <= idx_in;
      out_val_ff <= out_val_in;
      out_lst_ff <= out_lst_in;
      out_drp_ff <= out_drp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

// ----- hdl/cocktail_shaker_sort.sv -----
// ----------------------------------------------------------------------------
// cocktail_shaker_sort
// Loads a list of signed values, sorts it ascending, streams it back out.
//
//   channel | dir | beat fields (low bit up)
//   --------+-----+--------------------------------------------------
//   req_    | in  | tdata: value[31:0]; tlast: last
//   rsp_    | out | tdata: value_res[31:0]; tlast: last_res; tuser: dropped
//
// Load: one beat per cycle into a 4-entry queue while it has room, drained at one
// beat per cycle while the back loads. Sort: shaker passes on a single-write-port
// memory: prime (PRIME0, PRIME1), step along the span (STEP), write back (END).
// Emit: each result is read from the registered memory (RD), then offered (OUT).
// Reset is synchronous; req_ stalls only when the queue fills, rsp_ holds on stall.
// ----------------------------------------------------------------------------
module cocktail_shaker_sort #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value_res[31:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // dropped
);

   css_pkg::entry_type push_data;
   css_pkg::entry_type pop_data;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop_ready;

   css_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   css_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   css_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/css_checker.sv -----
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks of the sorter's input and result streams.
// ----------------------------------------------------------------------------
module css_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   logic        rsp_beat;
   logic        mid_ff;
   logic        drop_ff;
   logic [31:0] prev_ff;

   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff  <= 1'b0;
         drop_ff <= 1'b0;
         prev_ff <= '0;
      end else if (rsp_beat) begin
         mid_ff  <= !rsp_tlast;
         drop_ff <= rsp_tuser;
         prev_ff <= rsp_tdata;
      end
   end

   a_out_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && mid_ff |-> $signed(rsp_tdata) >= $signed(prev_ff))
      else $error("results out of order");

   a_drop_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && mid_ff |-> rsp_tuser == drop_ff)
      else $error("drop flag changed within a list");

   a_input_seen: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |-> !$isunknown(req_tdata))
      else $error("unknown value on final input beat");

endmodule

bind cocktail_shaker_sort css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ----- test/tb_cocktail_shaker_sort.sv -----
// ----------------------------------------------------------------------------
// tb_cocktail_shaker_sort
// Streams lists of signed values into the sorter and checks each returned
// beat against a local sort of the same list. Covers single-element lists,
// extreme and equal values, full and overflowing lists, and random short
// lists, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_cocktail_shaker_sort;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN     = 64;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE      = 300;

   typedef struct {
      logic [31:0] value;
      logic        last;
      logic        dropped;
   } sorted_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // value[31:0]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // value_res[31:0]
   logic        rsp_tlast;
   logic        rsp_tuser;          // dropped

   logic signed [31:0] list_store [MAX_LEN];
   int                 list_len      = 0;
   bit                 list_overflow = 1'b0;
   sorted_beat_type    sorted_expect [$];
   logic [31:0]        pending [$];
   int                 bad_count     = 0;
   int                 cycle_count   = 0;
   int                 sent_count    = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   cocktail_shaker_sort #(.MAX_LEN(MAX_LEN)) dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void report_bad(string field, logic [31:0] want, logic [31:0] got);
      if (bad_count < MAX_REPORTS)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
      bad_count++;
   endfunction

   // Sort the stored list ascending and queue one beat per element.
   function automatic void close_list();
      logic signed [31:0] key;
      int                 j;
      sorted_beat_type    beat;
      for (int i = 1; i < list_len; i++) begin
         key = list_store[i];
         j = i - 1;
         while (j >= 0 && list_store[j] > key) begin
            list_store[j + 1] = list_store[j];
            j--;
         end
         list_store[j + 1] = key;
      end
      for (int i = 0; i < list_len; i++) begin
         beat.value   = list_store[i];
         beat.last    = (i == list_len - 1);
         beat.dropped = list_overflow;
         sorted_expect.push_back(beat);
      end
      list_len      = 0;
      list_overflow = 1'b0;
   endfunction

   function automatic void predict_accept(logic [31:0] value, logic last);
      if (list_len < MAX_LEN) begin
         list_store[list_len] = value;
         list_len++;
      end else begin
         list_overflow = 1'b1;
      end
      if (last)
         close_list();
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(5))
         0:       return 32'h8000_0000 + $urandom_range(3);
         1:       return 32'h7fff_ffff - $urandom_range(3);
         2:       return $urandom_range(3);
         3:       return 32'hffff_fffe + $urandom_range(3);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_value(input logic [31:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      predict_accept(value, last);
      sent_count++;
   endtask

   task automatic send_pending();
      foreach (pending[i])
         send_value(pending[i], i == pending.size() - 1);
   endtask

   task automatic send_random_list(input int len);
      pending.delete();
      repeat (len) pending.push_back(random_value());
      send_pending();
   endtask

   // Hold the source until every sorted beat is back.
   task automatic drain_sorted();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sorted_expect.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed();
      pending = {32'h8000_0000};
      send_pending();
      pending = {32'h7fff_ffff};
      send_pending();
      pending = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
      send_pending();
      pending = {32'h0000_0005, 32'h0000_0005, 32'hffff_fffb, 32'h0000_0005};
      send_pending();
      pending = {32'h4, 32'h3, 32'h2, 32'h1, 32'h0, 32'hffff_ffff};
      send_pending();
      pending = {32'hffff_fffd, 32'hffff_fffe, 32'hffff_ffff, 32'h0};
      send_pending();
   endtask

   // Fill the store exactly, then overflow with the last mark on a dropped beat.
   task automatic test_capacity();
      send_random_list(MAX_LEN + 1);
   endtask

   task automatic test_random_lists(input int target);
      int start;
      int pick;
      int len;
      start = sent_count;
      while (sent_count - start < target) begin
         pick = $urandom_range(19);
         if (pick < 4)
            len = $urandom_range(9, 12);
         else
            len = $urandom_range(1, 8);
         send_random_list(len);
      end
   endtask

   always @(posedge clock) begin : sorted_check
      sorted_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_expect.size() == 0) begin
            report_bad("unexpected beat", 32'h0, rsp_tdata);
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_tdata !== want.value)
               report_bad("value_res", want.value, rsp_tdata);
            if (rsp_tlast !== want.last)
               report_bad("last_res", {31'b0, want.last}, {31'b0, rsp_tlast});
            if (rsp_tuser !== want.dropped)
               report_bad("dropped", {31'b0, want.dropped}, {31'b0, rsp_tuser});
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_cocktail_shaker_sort failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 51;
      test_directed();
      test_random_lists(8);
      drain_sorted();

      send_idle_pct = 51;
      recv_idle_pct = 10;
      test_capacity();
      test_random_lists(8);
      drain_sorted();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lists(14);
      drain_sorted();

      repeat (SETTLE) @(posedge clock);
      bad_count += sorted_expect.size();
      if (bad_count == 0)
         $display("tb_cocktail_shaker_sort passed");
      else
         $display("tb_cocktail_shaker_sort failed");
      $finish;
   end

endmodule
